FILE: rtl/core/mfpd_pkg.sv
// Shared constants, codes and types of the matched-filter preamble detector.
`default_nettype none

package mfpd_pkg;

  // Parameter defaults
  localparam int MaxTapsDef    = 256;
  localparam int SampleBitsDef = 16;
  localparam int MaxRecordDef  = 65536;

  // Fixed field widths
  localparam int TapIdxW  = 8;
  localparam int TapW     = 16;
  localparam int CorrW    = 40;
  localparam int PosW     = 16;
  localparam int RefLenW  = 9;
  localparam int ThrW     = 16;
  localparam int NoiseW   = 48;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 48;

  // Result word layout: {kind, correlation, position, detected, last}
  localparam int ResW = 1 + CorrW + PosW + 1 + 1;

  // Queue depths
  localparam int CmdDepth = 2;
  localparam int ResDepth = 2;

  localparam logic [PosW-1:0] PosMax = '1;

  // Register reset values
  localparam logic [RefLenW-1:0] RefLenRst = 9'd64;
  localparam logic [ThrW-1:0]    ThrRst    = 16'd256;
  localparam logic [NoiseW-1:0]  NoiseRst  = 48'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_REF_LEN   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_NOISE     = 2'd2
  } reg_idx_e;

  // Item and result kind codes
  localparam logic KindLoad   = 1'b0;
  localparam logic KindSample = 1'b1;
  localparam logic ResCorr    = 1'b0;
  localparam logic ResVerdict = 1'b1;

  // Request to the verdict unit
  typedef struct packed {
    logic                    start;
    logic signed [CorrW-1:0] value;
    logic [ThrW-1:0]         thr;
    logic [NoiseW-1:0]       noise;
  } vreq_t;

  // Answer of the verdict unit
  typedef struct packed {
    logic done;
    logic det;
  } vres_t;

endpackage

`default_nettype wire

FILE: rtl/core/matched_filter_preamble_detector.sv
// A tap load is written to the reference store in the back end; a sample takes len MAC steps
// from the command queue to its correlation word, len being ref_len clipped to 1..MAX_TAPS.
// Samples are taken one at a time: the single MAC steps one tap per cycle through the window
// and reference stores, and a full result queue holds off the next; end of record adds a verdict.
// Reset: control state, record state and registers clear at once (ref_len 64, threshold 256,
// noise 1); tap and window stores hold no reset value, and no clearing pass runs.
`default_nettype none

module matched_filter_preamble_detector
  import mfpd_pkg::*;
#(
  parameter int MAX_TAPS    = MaxTapsDef,
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int MAX_RECORD  = MaxRecordDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Item side
  input  logic                          push,
  output logic                          full,
  input  logic                          kind_i,
  input  logic [TapIdxW-1:0]            tap_index_i,
  input  logic signed [TapW-1:0]        tap_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          end_of_record_i,
  // Result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          result_kind_o,
  output logic signed [CorrW-1:0]       correlation_o,
  output logic [PosW-1:0]               position_o,
  output logic                          detected_o,
  output logic                          last_result_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [CfgDataW-1:0]           cfg_wdata_i
);

  localparam int CmdW = 2 + TapIdxW + TapW + SAMPLE_BITS;
  localparam int LenW = $clog2(MAX_TAPS + 1);

  logic [RefLenW-1:0] ref_len_q;
  logic [ThrW-1:0]    thr_q;
  logic [NoiseW-1:0]  noise_q;
  logic [LenW-1:0]    len;

  logic               cmd_valid, cmd_pop;
  logic [CmdW-1:0]    cmd;
  logic               res_push, res_full;
  logic [ResW-1:0]    res_in, res_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_len_q <= RefLenRst;
      thr_q     <= ThrRst;
      noise_q   <= NoiseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REF_LEN:   ref_len_q <= cfg_wdata_i[RefLenW-1:0];
        REG_THRESHOLD: thr_q     <= cfg_wdata_i[ThrW-1:0];
        REG_NOISE:     noise_q   <= cfg_wdata_i[NoiseW-1:0];
        default:       ;
      endcase
    end
  end

  // Clip the tap count to 1..MAX_TAPS
  always_comb begin
    if (ref_len_q == '0) begin
      len = LenW'(1);
    end else if (int'(ref_len_q) > MAX_TAPS) begin
      len = LenW'(MAX_TAPS);
    end else begin
      len = LenW'(ref_len_q);
    end
  end

  mfpd_front #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .tap_index_i    (tap_index_i),
    .tap_value_i    (tap_value_i),
    .sample_i       (sample_i),
    .end_of_record_i(end_of_record_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  mfpd_back #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_RECORD (MAX_RECORD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .len_i      (len),
    .thr_i      (thr_q),
    .noise_i    (noise_q),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue
  mfpd_fifo #(
    .WIDTH(ResW),
    .DEPTH(ResDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  // Unpack the head word
  assign result_kind_o = res_out[ResW-1];
  assign correlation_o = res_out[ResW-2 -: CorrW];
  assign position_o    = res_out[PosW+1:2];
  assign detected_o    = res_out[1];
  assign last_result_o = res_out[0];

endmodule

`default_nettype wire

FILE: rtl/core/mfpd_fifo.sv
// Small register queue with push/full and pop/empty sides.
`default_nettype none

module mfpd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfpd_front.sv
// Front end: accepts items, drops out-of-range tap loads, queues commands.
`default_nettype none

module mfpd_front
  import mfpd_pkg::*;
#(
  parameter int MAX_TAPS    = MaxTapsDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      push,
  output logic                                      full,
  input  logic                                      kind_i,
  input  logic [TapIdxW-1:0]                        tap_index_i,
  input  logic signed [TapW-1:0]                    tap_value_i,
  input  logic signed [SAMPLE_BITS-1:0]             sample_i,
  input  logic                                      end_of_record_i,
  output logic                                      cmd_valid_o,
  output logic [2+TapIdxW+TapW+SAMPLE_BITS-1:0]     cmd_o,
  input  logic                                      cmd_pop_i
);

  localparam int CmdW = 2 + TapIdxW + TapW + SAMPLE_BITS;

  logic            keep;
  logic            q_push;
  logic            q_empty;
  logic [CmdW-1:0] cmd_in;

  // Classify: samples always pass, loads only inside the tap store
  assign keep   = (kind_i == KindSample) || (int'(tap_index_i) < MAX_TAPS);
  assign q_push = push & ~full & keep;
  assign cmd_in = {kind_i, end_of_record_i, tap_index_i, tap_value_i, sample_i};

  mfpd_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(q_empty)
  );

  assign cmd_valid_o = ~q_empty;

endmodule

`default_nettype wire

FILE: rtl/core/mfpd_verdict.sv
// Verdict unit: compares peak^2 * 256 against threshold * noise.
`default_nettype none

module mfpd_verdict
  import mfpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  vreq_t vreq_i,
  output vres_t vres_o
);

  localparam int HalfW   = CorrW / 2;
  localparam int OpW     = 24;
  localparam int ProdW   = 2 * OpW;
  localparam int SqW     = 2 * CorrW;
  localparam int RhsW    = ThrW + NoiseW;
  localparam int ScaleSh = 8;
  localparam int CmpW    = SqW + ScaleSh;

  localparam logic [2:0] StepLoLo  = 3'd0;
  localparam logic [2:0] StepLoHi  = 3'd1;
  localparam logic [2:0] StepHiHi  = 3'd2;
  localparam logic [2:0] StepThrLo = 3'd3;
  localparam logic [2:0] StepThrHi = 3'd4;
  localparam logic [2:0] StepEnd   = 3'd5;

  typedef enum logic [1:0] {
    V_IDLE,
    V_RUN,
    V_CMP
  } vstate_e;

  vstate_e          state_q;
  logic [CorrW-1:0] mag, mag_q;
  logic [2:0]       step_q, pstep_q;
  logic             pv_q;
  logic [ProdW-1:0] prod_q;
  logic [SqW-1:0]   sq_q;
  logic [RhsW-1:0]  rhs_q;
  logic [OpW-1:0]   op_a, op_b;
  logic             done_q, det_q;

  // Magnitude of the peak; the most negative value maps to 2^39
  assign mag = vreq_i.value[CorrW-1] ? CorrW'(-vreq_i.value) : CorrW'(vreq_i.value);

  // Pick the operand pair of the current partial product
  always_comb begin
    case (step_q)
      StepLoLo: begin
        op_a = OpW'(mag_q[HalfW-1:0]);
        op_b = OpW'(mag_q[HalfW-1:0]);
      end
      StepLoHi: begin
        op_a = OpW'(mag_q[HalfW-1:0]);
        op_b = OpW'(mag_q[CorrW-1:HalfW]);
      end
      StepHiHi: begin
        op_a = OpW'(mag_q[CorrW-1:HalfW]);
        op_b = OpW'(mag_q[CorrW-1:HalfW]);
      end
      StepThrLo: begin
        op_a = OpW'(vreq_i.thr);
        op_b = vreq_i.noise[OpW-1:0];
      end
      StepThrHi: begin
        op_a = OpW'(vreq_i.thr);
        op_b = vreq_i.noise[NoiseW-1:OpW];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Sequence the partial products, accumulate, then compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= V_IDLE;
      mag_q   <= '0;
      step_q  <= StepLoLo;
      pstep_q <= StepLoLo;
      pv_q    <= 1'b0;
      prod_q  <= '0;
      sq_q    <= '0;
      rhs_q   <= '0;
      done_q  <= 1'b0;
      det_q   <= 1'b0;
    end else begin
      done_q <= (state_q == V_CMP);
      unique case (state_q)
        V_IDLE: begin
          if (vreq_i.start) begin
            mag_q   <= mag;
            sq_q    <= '0;
            rhs_q   <= '0;
            step_q  <= StepLoLo;
            pv_q    <= 1'b0;
            state_q <= V_RUN;
          end
        end
        V_RUN: begin
          if (step_q != StepEnd) begin
            prod_q  <= ProdW'(op_a) * ProdW'(op_b);
            pstep_q <= step_q;
            pv_q    <= 1'b1;
            step_q  <= step_q + 3'd1;
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q) begin
            case (pstep_q)
              StepLoLo:  sq_q  <= sq_q + SqW'(prod_q);
              StepLoHi:  sq_q  <= sq_q + (SqW'(prod_q) << (HalfW + 1));
              StepHiHi:  sq_q  <= sq_q + (SqW'(prod_q) << (2 * HalfW));
              StepThrLo: rhs_q <= rhs_q + RhsW'(prod_q);
              StepThrHi: rhs_q <= rhs_q + (RhsW'(prod_q) << OpW);
              default:   sq_q  <= sq_q;
            endcase
          end
          if ((step_q == StepEnd) && !pv_q) begin
            state_q <= V_CMP;
          end
        end
        V_CMP: begin
          det_q   <= {sq_q, {ScaleSh{1'b0}}} > CmpW'(rhs_q);
          state_q <= V_IDLE;
        end
        default: state_q <= V_IDLE;
      endcase
    end
  end

  assign vres_o.done = done_q;
  assign vres_o.det  = det_q;

endmodule

`default_nettype wire

FILE: rtl/core/mfpd_back.sv
// Back end: tap and window stores, shared MAC, peak tracking and result words.
`default_nettype none

module mfpd_back
  import mfpd_pkg::*;
#(
  parameter int MAX_TAPS    = MaxTapsDef,
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int MAX_RECORD  = MaxRecordDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cmd_valid_i,
  input  logic [2+TapIdxW+TapW+SAMPLE_BITS-1:0]  cmd_i,
  output logic                                   cmd_pop_o,
  input  logic [$clog2(MAX_TAPS+1)-1:0]          len_i,
  input  logic [ThrW-1:0]                        thr_i,
  input  logic [NoiseW-1:0]                      noise_i,
  input  logic                                   res_full_i,
  output logic                                   res_push_o,
  output logic [ResW-1:0]                        res_o
);

  localparam int CmdW   = 2 + TapIdxW + TapW + SAMPLE_BITS;
  localparam int AddrW  = $clog2(MAX_TAPS);
  localparam int LenW   = $clog2(MAX_TAPS + 1);
  localparam int SeenW  = $clog2(MAX_RECORD + 1);
  localparam int ProdW  = SAMPLE_BITS + TapW;
  localparam int AccRaw = ProdW + AddrW + 1;
  localparam int AccW   = (AccRaw > CorrW) ? AccRaw : CorrW + 1;
  localparam int MaxW   = (SeenW > LenW) ? SeenW : LenW;
  localparam int PW     = (MaxW > PosW) ? MaxW : PosW + 1;
  localparam int TW     = LenW + 1;

  localparam logic signed [CorrW-1:0] CorrMax = {1'b0, {(CorrW-1){1'b1}}};
  localparam logic signed [CorrW-1:0] CorrMin = {1'b1, {(CorrW-1){1'b0}}};

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_COUT,
    BK_VSTART,
    BK_VWAIT,
    BK_VOUT
  } bstate_e;

  // Command fields
  logic                          cmd_kind, cmd_eor;
  logic [TapIdxW-1:0]            cmd_idx;
  logic signed [TapW-1:0]        cmd_tap;
  logic signed [SAMPLE_BITS-1:0] cmd_smp;

  assign cmd_kind = cmd_i[CmdW-1];
  assign cmd_eor  = cmd_i[CmdW-2];
  assign cmd_idx  = cmd_i[CmdW-3 -: TapIdxW];
  assign cmd_tap  = cmd_i[SAMPLE_BITS+TapW-1 -: TapW];
  assign cmd_smp  = cmd_i[SAMPLE_BITS-1:0];

  // Stores
  logic signed [SAMPLE_BITS-1:0] win_mem [MAX_TAPS];
  logic signed [TapW-1:0]        tap_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] win_rd_q;
  logic signed [TapW-1:0]        tap_rd_q;

  bstate_e                 state_q;
  logic [AddrW-1:0]        wp_q, wp_next;
  logic [SeenW-1:0]        seen_q, seen_inc;
  logic signed [CorrW-1:0] best_q;
  logic [PosW-1:0]         best_idx_q;
  logic                    have_best_q;
  logic                    eor_q;
  logic [PosW-1:0]         pos_q, pos;
  logic [AddrW-1:0]        rd_addr_q, rd_next, start;
  logic [LenW-1:0]         tap_cnt_q;
  logic                    v1_q, v2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    vdet_q;

  logic                    take_load, take_smp, fire, issue, better;
  logic [PW-1:0]           mx;
  logic [TW-1:0]           t_raw;
  logic [AccW-CorrW:0]     acc_hi;
  logic signed [CorrW-1:0] corr_sat;
  vreq_t                   vreq;
  vres_t                   vres;

  assign cmd_pop_o = (state_q == BK_IDLE) & cmd_valid_i;
  assign take_load = cmd_pop_o & (cmd_kind == KindLoad);
  assign take_smp  = cmd_pop_o & (cmd_kind == KindSample);

  // Record position: saturating count, window start and its clipped index
  assign seen_inc = (seen_q < SeenW'(MAX_RECORD)) ? seen_q + SeenW'(1) : seen_q;
  assign fire     = PW'(seen_inc) >= PW'(len_i);
  assign mx       = PW'(seen_inc) - PW'(len_i);
  assign pos      = (mx > PW'(PosMax)) ? PosMax : PosW'(mx);

  // Oldest sample of the window once the new one is written
  assign wp_next = (wp_q == AddrW'(MAX_TAPS - 1)) ? '0 : wp_q + AddrW'(1);
  assign t_raw   = TW'(wp_q) + TW'(MAX_TAPS) + TW'(1) - TW'(len_i);
  assign start   = (t_raw >= TW'(MAX_TAPS)) ? AddrW'(t_raw - TW'(MAX_TAPS)) : AddrW'(t_raw);
  assign rd_next = (rd_addr_q == AddrW'(MAX_TAPS - 1)) ? '0 : rd_addr_q + AddrW'(1);

  assign issue = (state_q == BK_MAC) && (tap_cnt_q != len_i);

  // Clip the sum to the correlation range
  assign acc_hi = acc_q[AccW-1:CorrW-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      corr_sat = acc_q[CorrW-1:0];
    end else if (acc_q[AccW-1]) begin
      corr_sat = CorrMin;
    end else begin
      corr_sat = CorrMax;
    end
  end

  assign better = !have_best_q || (corr_sat > best_q);

  // Result word
  always_comb begin
    if (state_q == BK_VOUT) begin
      res_o = {ResVerdict, best_q, (vdet_q ? best_idx_q : PosW'(0)), vdet_q, 1'b1};
    end else begin
      res_o = {ResCorr, corr_sat, pos_q, 1'b0, ~eor_q};
    end
  end
  assign res_push_o = ((state_q == BK_COUT) || (state_q == BK_VOUT)) & ~res_full_i;

  // Window store: write the new sample, read one tap position per cycle
  always_ff @(posedge clk_i) begin
    if (take_smp) begin
      win_mem[wp_q] <= cmd_smp;
    end
    if (issue) begin
      win_rd_q <= win_mem[rd_addr_q];
    end
  end

  // Reference store
  always_ff @(posedge clk_i) begin
    if (take_load) begin
      tap_mem[AddrW'(cmd_idx)] <= cmd_tap;
    end
    if (issue) begin
      tap_rd_q <= tap_mem[tap_cnt_q[AddrW-1:0]];
    end
  end

  // Sequencer, MAC pipeline and record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wp_q        <= '0;
      seen_q      <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      have_best_q <= 1'b0;
      eor_q       <= 1'b0;
      pos_q       <= '0;
      rd_addr_q   <= '0;
      tap_cnt_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      vdet_q      <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (v1_q) begin
        prod_q <= win_rd_q * tap_rd_q;
      end
      if (v2_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
      unique case (state_q)
        BK_IDLE: begin
          if (take_smp) begin
            wp_q      <= wp_next;
            seen_q    <= seen_inc;
            eor_q     <= cmd_eor;
            pos_q     <= pos;
            rd_addr_q <= start;
            tap_cnt_q <= '0;
            acc_q     <= '0;
            if (fire) begin
              state_q <= BK_MAC;
            end else if (cmd_eor) begin
              state_q <= BK_VSTART;
            end
          end
        end
        BK_MAC: begin
          if (issue) begin
            rd_addr_q <= rd_next;
            tap_cnt_q <= tap_cnt_q + LenW'(1);
          end else if (!v1_q && !v2_q) begin
            state_q <= BK_COUT;
          end
        end
        BK_COUT: begin
          if (!res_full_i) begin
            if (better) begin
              best_q      <= corr_sat;
              best_idx_q  <= pos_q;
              have_best_q <= 1'b1;
            end
            state_q <= eor_q ? BK_VSTART : BK_IDLE;
          end
        end
        BK_VSTART: state_q <= BK_VWAIT;
        BK_VWAIT: begin
          if (vres.done) begin
            vdet_q  <= vres.det & have_best_q;
            state_q <= BK_VOUT;
          end
        end
        BK_VOUT: begin
          if (!res_full_i) begin
            seen_q      <= '0;
            best_q      <= '0;
            best_idx_q  <= '0;
            have_best_q <= 1'b0;
            state_q     <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  // Verdict unit
  assign vreq.start = (state_q == BK_VSTART);
  assign vreq.value = best_q;
  assign vreq.thr   = thr_i;
  assign vreq.noise = noise_i;

  mfpd_verdict u_verdict (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vreq_i(vreq),
    .vres_o(vres)
  );

  a_mac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MAC) |-> (tap_cnt_q <= len_i))
    else $error("MAC issued more taps than in use");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vres.done |-> (state_q == BK_VWAIT))
    else $error("verdict finished while not awaited");

  a_record_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_VOUT) && !res_full_i) |=> ((seen_q == '0) && !have_best_q))
    else $error("record not cleared after verdict");

  a_best_has_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> (seen_q != '0))
    else $error("peak held with no samples in record");

endmodule

`default_nettype wire
